// File: src/frame_average_background_model_core_defines.svh
// Assertion macros for the block's modules (used by fabm_back).
// They expect signals named clk and rst_n in the module that uses them.
`ifndef FRAME_AVERAGE_BACKGROUND_MODEL_CORE_DEFINES_SVH
`define FRAME_AVERAGE_BACKGROUND_MODEL_CORE_DEFINES_SVH

`define FABM_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FABM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fabm_pkg.sv
package fabm_pkg;

  localparam int IDX_W     = 20;
  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 3;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_FLOOR = 2'd2;

  localparam logic OP_LEARN    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [CFG_W-1:0] HIGH_SCALE_RST = 4'd7;
  localparam logic [CFG_W-1:0] LOW_SCALE_RST  = 4'd8;
  localparam logic [CFG_W-1:0] DIFF_FLOOR_RST = 4'd1;

  localparam logic [CHAN_W-1:0] FG_VALUE = 8'd255;

  typedef logic [NCHAN-1:0][CHAN_W-1:0] pix_t;

  typedef enum logic [1:0] {
    CMD_FIRST,
    CMD_ACCUM,
    CMD_CLASSIFY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    pix_t             pix;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] high_scale;
    logic [CFG_W-1:0] low_scale;
    logic [CFG_W-1:0] diff_floor;
  } cfg_t;

  typedef struct packed {
    logic [NCHAN-1:0][SUM_W-1:0] sum;
    logic [NCHAN-1:0][SUM_W-1:0] dsum;
    pix_t                        prev;
  } entry_t;

endpackage

// File: src/frame_average_background_model_core.sv
// Per-pixel averaging background model for 3-channel 8-bit video. Learn items
// (opcode 0) build per-pixel channel sums and sums of frame-to-frame absolute
// differences in a single-port memory of MAX_PIXELS entries; the first learn
// frame only stores the pixel. Classify items (opcode 1) give one result each,
// foreground with all channels at 255 when any channel falls outside its bounds.
// The memory is not cleared: classifying a pixel that was never learned reads
// an unwritten entry. Items pass front stages s1 and s2 (index reduction, sort),
// a four-entry queue and the memory engine, which takes an item only in idle;
// learn items pass read and exec, classify items also bound and result, stalling
// on out_ready. The front takes one item a cycle until the queue fills. Learn
// items past MAX_FRAMES + 1 learned frames are discarded in the front stage.
// Configuration writes are taken at once and should only be made while idle.
module frame_average_background_model_core #(
  parameter int MAX_PIXELS = 1048576,
  parameter int MAX_FRAMES = 1023
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fabm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fabm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [fabm_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic [fabm_pkg::CHAN_W-1:0]        in_chan0,
  input  logic [fabm_pkg::CHAN_W-1:0]        in_chan1,
  input  logic [fabm_pkg::CHAN_W-1:0]        in_chan2,
  input  logic                               in_end_of_frame,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fabm_pkg::CHAN_W-1:0]        out_chan0,
  output logic [fabm_pkg::CHAN_W-1:0]        out_chan1,
  output logic [fabm_pkg::CHAN_W-1:0]        out_chan2,
  output logic                               out_foreground
);

  localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CMD_W   = $bits(fabm_pkg::cmd_t);
  localparam int ENTRY_W = ADDR_W + CMD_W;

  fabm_pkg::cfg_t       cfg_r;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  logic [ADDR_W-1:0]    f_addr;
  fabm_pkg::cmd_t       f_cmd;
  logic [ENTRY_W-1:0]   q_out;
  logic [ADDR_W-1:0]    b_addr;
  fabm_pkg::cmd_t       b_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_scale <= fabm_pkg::HIGH_SCALE_RST;
      cfg_r.low_scale  <= fabm_pkg::LOW_SCALE_RST;
      cfg_r.diff_floor <= fabm_pkg::DIFF_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fabm_pkg::REG_HIGH_SCALE: cfg_r.high_scale <= cfg_data;
        fabm_pkg::REG_LOW_SCALE:  cfg_r.low_scale  <= cfg_data;
        fabm_pkg::REG_DIFF_FLOOR: cfg_r.diff_floor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fabm_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_FRAMES (MAX_FRAMES),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_pixel_index  (in_pixel_index),
    .in_chan0        (in_chan0),
    .in_chan1        (in_chan1),
    .in_chan2        (in_chan2),
    .in_end_of_frame (in_end_of_frame),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_addr          (f_addr),
    .q_cmd           (f_cmd)
  );

  fabm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_addr, f_cmd}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign b_addr = q_out[ENTRY_W-1:CMD_W];
  assign b_cmd  = fabm_pkg::cmd_t'(q_out[CMD_W-1:0]);

  fabm_back #(
    .MAX_PIXELS (MAX_PIXELS),
    .ADDR_W     (ADDR_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_addr         (b_addr),
    .q_cmd          (b_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chan0      (out_chan0),
    .out_chan1      (out_chan1),
    .out_chan2      (out_chan2),
    .out_foreground (out_foreground)
  );

endmodule

// File: src/fabm_front.sv
module fabm_front #(
  parameter int MAX_PIXELS = 1048576,
  parameter int MAX_FRAMES = 1023,
  parameter int ADDR_W     = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [fabm_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [fabm_pkg::CHAN_W-1:0]   in_chan0,
  input  logic [fabm_pkg::CHAN_W-1:0]   in_chan1,
  input  logic [fabm_pkg::CHAN_W-1:0]   in_chan2,
  input  logic                          in_end_of_frame,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [ADDR_W-1:0]             q_addr,
  output fabm_pkg::cmd_t                q_cmd
);

  localparam int IDX_W   = fabm_pkg::IDX_W;
  localparam int CNT_W   = fabm_pkg::CNT_W;
  localparam int LOG_M   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SHIFT   = IDX_W + LOG_M;
  localparam int RECIP_W = IDX_W + 2;
  localparam int PROD_W  = IDX_W + RECIP_W;
  localparam int MP_W    = $clog2(MAX_PIXELS + 1);
  localparam int REM_W   = IDX_W + MP_W;
  localparam logic [63:0] RECIP = (64'd1 << SHIFT) / MAX_PIXELS;

  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [IDX_W-1:0]       s1_idx_r;
  fabm_pkg::pix_t         s1_pix_r;
  logic                   s1_eof_r;

  logic                   s2_valid_r;
  logic                   s2_op_r;
  logic [IDX_W-1:0]       s2_idx_r;
  fabm_pkg::pix_t         s2_pix_r;
  logic                   s2_eof_r;
  logic [IDX_W-1:0]       s2_quot_r;

  logic [CNT_W-1:0]       frames_r;
  logic [CNT_W-1:0]       frames_nxt;
  logic                   first_done_r;
  logic                   first_done_nxt;

  logic [PROD_W-1:0]      prod;
  logic [IDX_W-1:0]       quot;
  logic [REM_W-1:0]       qm;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_fix;
  logic                   frames_full;
  logic                   drop;
  logic                   s2_go;
  logic                   s2_free;
  logic                   s1_go;

  // The quotient estimate is at most one short, so one subtraction corrects it.
  assign prod = PROD_W'(s1_idx_r) * PROD_W'(RECIP[RECIP_W-1:0]);
  assign quot = IDX_W'(prod >> SHIFT);
  assign qm   = REM_W'(s2_quot_r) * REM_W'(MAX_PIXELS);
  assign rem  = REM_W'(s2_idx_r) - qm;
  assign rem_fix = (rem >= REM_W'(MAX_PIXELS)) ? rem - REM_W'(MAX_PIXELS) : rem;

  assign frames_full = (frames_r >= CNT_W'(MAX_FRAMES));
  assign drop        = (s2_op_r == fabm_pkg::OP_LEARN) && frames_full;

  assign s2_go    = s2_valid_r && (drop || !q_full);
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s1_go;

  assign q_push    = s2_valid_r && !drop && !q_full;
  assign q_addr    = rem_fix[ADDR_W-1:0];

  always_comb begin
    q_cmd.pix   = s2_pix_r;
    q_cmd.count = frames_r;
    if (s2_op_r == fabm_pkg::OP_CLASSIFY) begin
      q_cmd.kind = fabm_pkg::CMD_CLASSIFY;
    end else if (!first_done_r) begin
      q_cmd.kind = fabm_pkg::CMD_FIRST;
    end else begin
      q_cmd.kind = fabm_pkg::CMD_ACCUM;
    end
  end

  always_comb begin
    frames_nxt     = frames_r;
    first_done_nxt = first_done_r;
    if (s2_go && !drop && s2_op_r == fabm_pkg::OP_LEARN && s2_eof_r) begin
      if (!first_done_r) begin
        first_done_nxt = 1'b1;
      end else begin
        frames_nxt = frames_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      frames_r     <= '0;
      first_done_r <= 1'b0;
    end else begin
      frames_r     <= frames_nxt;
      first_done_r <= first_done_nxt;
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_r <= 1'b1;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= in_opcode;
      s1_idx_r <= in_pixel_index;
      s1_pix_r <= {in_chan2, in_chan1, in_chan0};
      s1_eof_r <= in_end_of_frame;
    end
    if (s1_go) begin
      s2_op_r   <= s1_op_r;
      s2_idx_r  <= s1_idx_r;
      s2_pix_r  <= s1_pix_r;
      s2_eof_r  <= s1_eof_r;
      s2_quot_r <= quot;
    end
  end

endmodule

// File: src/fabm_queue.sv
module fabm_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/fabm_back.sv
`include "frame_average_background_model_core_defines.svh"

module fabm_back #(
  parameter int MAX_PIXELS = 1048576,
  parameter int ADDR_W     = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fabm_pkg::cfg_t               cfg,
  input  logic                         q_empty,
  input  logic [ADDR_W-1:0]            q_addr,
  input  fabm_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fabm_pkg::CHAN_W-1:0]  out_chan0,
  output logic [fabm_pkg::CHAN_W-1:0]  out_chan1,
  output logic [fabm_pkg::CHAN_W-1:0]  out_chan2,
  output logic                         out_foreground
);

  localparam int NCHAN  = fabm_pkg::NCHAN;
  localparam int SUM_W  = fabm_pkg::SUM_W;
  localparam int CHAN_W = fabm_pkg::CHAN_W;
  localparam int CNT_W  = fabm_pkg::CNT_W;
  localparam int DIFF_W = SUM_W + 1;
  localparam int BND_W  = DIFF_W + fabm_pkg::CFG_W + 1;
  localparam int V_W    = CNT_W + CHAN_W;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_EXEC,
    B_BOUND,
    B_RESULT
  } state_t;

  state_t                          state_r;
  logic [ADDR_W-1:0]               addr_r;
  fabm_pkg::cmd_t                  cmd_r;
  fabm_pkg::entry_t                rd_r;
  fabm_pkg::entry_t                wr_data;
  logic                            wr_en;
  logic [NCHAN-1:0][DIFF_W-1:0]    d_r;
  logic [NCHAN-1:0][DIFF_W-1:0]    d_nxt;
  logic [NCHAN-1:0][BND_W-1:0]     lo_r;
  logic [NCHAN-1:0][BND_W-1:0]     lo_nxt;
  logic [NCHAN-1:0][BND_W-1:0]     hi_r;
  logic [NCHAN-1:0][BND_W-1:0]     hi_nxt;
  logic [NCHAN-1:0][V_W-1:0]       v_r;
  logic [NCHAN-1:0][V_W-1:0]       v_nxt;
  logic                            fg;
  logic                            res_load;
  logic                            out_valid_r;
  fabm_pkg::pix_t                  out_pix_r;
  logic                            out_fg_r;

  fabm_pkg::entry_t entry_mem [MAX_PIXELS];

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign wr_en    = (state_r == B_EXEC) && (cmd_r.kind != fabm_pkg::CMD_CLASSIFY);
  assign res_load = (state_r == B_RESULT) && (!out_valid_r || out_ready);

  always_comb begin
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] q;
    logic [CHAN_W-1:0] ad;
    wr_data.prev = cmd_r.pix;
    for (int c = 0; c < NCHAN; c++) begin
      p  = cmd_r.pix[c];
      q  = rd_r.prev[c];
      ad = (p > q) ? p - q : q - p;
      if (cmd_r.kind == fabm_pkg::CMD_FIRST) begin
        wr_data.sum[c]  = '0;
        wr_data.dsum[c] = '0;
      end else begin
        wr_data.sum[c]  = rd_r.sum[c] + SUM_W'(p);
        wr_data.dsum[c] = rd_r.dsum[c] + SUM_W'(ad);
      end
    end
  end

  // The bounds are kept cross-multiplied: a channel is foreground when
  // count*p + low*d falls below the sum, or count*p exceeds sum + high*d.
  always_comb begin
    fg = 1'b0;
    for (int c = 0; c < NCHAN; c++) begin
      d_nxt[c]  = DIFF_W'(rd_r.dsum[c])
                + DIFF_W'(cfg.diff_floor) * DIFF_W'(cmd_r.count);
      v_nxt[c]  = V_W'(cmd_r.count) * V_W'(cmd_r.pix[c]);
      lo_nxt[c] = BND_W'(v_nxt[c]) + BND_W'(cfg.low_scale) * BND_W'(d_r[c]);
      hi_nxt[c] = BND_W'(rd_r.sum[c]) + BND_W'(cfg.high_scale) * BND_W'(d_r[c]);
      if (lo_r[c] < BND_W'(rd_r.sum[c]) || BND_W'(v_r[c]) > hi_r[c]) begin
        fg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_READ) begin
      rd_r <= entry_mem[addr_r];
    end
    if (wr_en) begin
      entry_mem[addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            addr_r  <= q_addr;
            cmd_r   <= q_cmd;
            state_r <= B_READ;
          end
        end
        B_READ: begin
          state_r <= B_EXEC;
        end
        B_EXEC: begin
          d_r <= d_nxt;
          if (cmd_r.kind == fabm_pkg::CMD_CLASSIFY) begin
            state_r <= B_BOUND;
          end else begin
            state_r <= B_IDLE;
          end
        end
        B_BOUND: begin
          lo_r    <= lo_nxt;
          hi_r    <= hi_nxt;
          v_r     <= v_nxt;
          state_r <= B_RESULT;
        end
        B_RESULT: begin
          if (res_load) begin
            out_fg_r <= fg;
            for (int c = 0; c < NCHAN; c++) begin
              out_pix_r[c] <= fg ? fabm_pkg::FG_VALUE : cmd_r.pix[c];
            end
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chan0      = out_pix_r[0];
  assign out_chan1      = out_pix_r[1];
  assign out_chan2      = out_pix_r[2];
  assign out_foreground = out_fg_r;

  `FABM_CHECK(a_pop_nonempty, q_pop, !q_empty, "Item taken from an empty queue.")
  `FABM_CHECK_NEXT(a_result_loaded, res_load, out_valid_r && state_r == B_IDLE, "No result.")
  `FABM_CHECK_NEXT(a_learn_silent, wr_en && !out_valid_r, !out_valid_r, "Learn item gave a result.")

endmodule
